[hdl/masked_byte_pattern_scanner_assert.svh]
// Assertion macros shared by the scanner RTL.
// No dependencies; include by bare file name.
`ifndef MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mbps_pkg.sv]
// Shared types, constants and helpers for the masked byte pattern scanner.
// No dependencies.
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int unsigned MAX_PATTERN_BYTES = 16;
  localparam int unsigned OFFSET_BITS       = 32;
  localparam int unsigned WIN_IDX_W         = $clog2(MAX_PATTERN_BYTES);
  localparam int unsigned LEN_W             = 5;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 64;

  typedef logic [MAX_PATTERN_BYTES-1:0][7:0] byte_vec_t;
  typedef logic [OFFSET_BITS-1:0]            count_t;
  typedef logic [LEN_W-1:0]                  len_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_CARE_MASK    = 2'd2,
    CFG_PATTERN_LEN  = 2'd3
  } cfg_reg_e;

  // Live configuration seen by the window comparator.
  typedef struct packed {
    byte_vec_t                    pattern;
    logic [MAX_PATTERN_BYTES-1:0] care;
    len_t                         len;     // already clamped to 1..MAX
  } match_cfg_t;

  // Clamp the programmed length into 1..MAX_PATTERN_BYTES.
  function automatic len_t eff_len(input len_t raw);
    len_t res;
    res = raw;
    if (raw == '0) begin
      res = len_t'(1);
    end else if (raw > len_t'(MAX_PATTERN_BYTES)) begin
      res = len_t'(MAX_PATTERN_BYTES);
    end
    return res;
  endfunction

endpackage

[hdl/mbps_window_cmp.sv]
// Masked compare of the newest window bytes against the pattern.
// Depends on mbps_pkg.
`timescale 1ns / 1ps

module mbps_window_cmp (
  input  mbps_pkg::byte_vec_t  window_i,  // newest byte at index 0
  input  mbps_pkg::match_cfg_t cfg_i,
  output logic                 hit_o
);

  logic [mbps_pkg::WIN_IDX_W-1:0] age;

  // Pattern byte k lines up with window age len-1-k.
  always_comb begin
    hit_o = 1'b1;
    age   = '0;
    for (int k = 0; k < int'(mbps_pkg::MAX_PATTERN_BYTES); k++) begin
      if ((k < int'(cfg_i.len)) && cfg_i.care[k]) begin
        age = mbps_pkg::WIN_IDX_W'(cfg_i.len - mbps_pkg::len_t'(1) - mbps_pkg::len_t'(k));
        if (window_i[age] != cfg_i.pattern[k]) begin
          hit_o = 1'b0;
        end
      end
    end
  end

endmodule

[hdl/masked_byte_pattern_scanner.sv]
// Masked byte pattern scanner: bytes pass the byte register, then the result register.
// Throughput one byte per cycle unless a result is blocked; the registers decouple sides.
// The input stall path follows result-side backpressure only for bytes that yield a result.
// Reset (rst_ni low, async) clears window, byte count, match flag and both valids;
// configuration resets to pattern zero, care mask all ones, length one.
// Depends on mbps_pkg, mbps_window_cmp and masked_byte_pattern_scanner_assert.svh.
`timescale 1ns / 1ps
`include "masked_byte_pattern_scanner_assert.svh"

module masked_byte_pattern_scanner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // byte stream in
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [7:0]                          s_tdata_i,   // [7:0] data_byte
  input  logic                                s_tlast_i,   // region_end
  // result stream out
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [31:0]                         m_tdata_o,   // [31:0] match_offset
  output logic                                m_tuser_o    // [0] match_found
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write only while the scanner is idle;
  // the block does not enforce this and always accepts writes.
  // ---------------------------------------------------------------------------
  logic [63:0]                          pat_low_q, pat_high_q;
  logic [mbps_pkg::MAX_PATTERN_BYTES-1:0] care_q;
  mbps_pkg::len_t                       len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= '1;
      len_q      <= mbps_pkg::len_t'(1);
    end else if (cfg_valid_i) begin
      case (mbps_pkg::cfg_reg_e'(cfg_index_i))
        mbps_pkg::CFG_PATTERN_LOW:  pat_low_q  <= cfg_data_i;
        mbps_pkg::CFG_PATTERN_HIGH: pat_high_q <= cfg_data_i;
        mbps_pkg::CFG_CARE_MASK:    care_q     <= cfg_data_i[mbps_pkg::MAX_PATTERN_BYTES-1:0];
        mbps_pkg::CFG_PATTERN_LEN:  len_q      <= cfg_data_i[mbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  mbps_pkg::match_cfg_t match_cfg;

  assign match_cfg.pattern = {pat_high_q, pat_low_q};
  assign match_cfg.care    = care_q;
  assign match_cfg.len     = mbps_pkg::eff_len(len_q);

  // ---------------------------------------------------------------------------
  // Input byte register.
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;     // byte in the input register is consumed this cycle
  logic       out_free;    // result register can take a new result

  assign s_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_byte_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Region state: sliding window (newest at index 0), saturating byte count,
  // and the sticky match flag that mutes the rest of the region.
  // ---------------------------------------------------------------------------
  mbps_pkg::byte_vec_t window_q, window_d;
  mbps_pkg::count_t    count_q, count_d;
  logic                matched_q, matched_d;
  mbps_pkg::byte_vec_t window_new;
  mbps_pkg::count_t    count_new;
  logic                cmp_hit;
  logic                hit;
  logic                produce;

  // Shift the pending byte in; hold the count at all ones once it saturates.
  assign window_new = {window_q[mbps_pkg::MAX_PATTERN_BYTES-2:0], in_byte_q};
  assign count_new  = (count_q == '1) ? count_q : count_q + mbps_pkg::count_t'(1);

  mbps_window_cmp u_cmp (
    .window_i (window_new),
    .cfg_i    (match_cfg),
    .hit_o    (cmp_hit)
  );

  // A window only counts once enough bytes of the region have gone by.
  assign hit     = cmp_hit && (count_new >= mbps_pkg::count_t'(match_cfg.len));
  assign produce = !matched_q && (hit || in_last_q);
  assign advance = in_valid_q && (!produce || out_free);

  always_comb begin
    window_d  = window_q;
    count_d   = count_q;
    matched_d = matched_q;
    if (advance) begin
      if (in_last_q) begin
        // Region ends: drop everything for the next one.
        window_d  = '0;
        count_d   = '0;
        matched_d = 1'b0;
      end else if (!matched_q) begin
        window_d  = window_new;
        count_d   = count_new;
        matched_d = hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= '0;
      count_q   <= '0;
      matched_q <= 1'b0;
    end else begin
      window_q  <= window_d;
      count_q   <= count_d;
      matched_q <= matched_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: a found result carries the window start offset, a
  // not-found result carries zero.
  // ---------------------------------------------------------------------------
  logic        out_valid_q;
  logic        out_found_q;
  logic [31:0] out_offset_q;
  logic        out_load;

  assign out_free = !out_valid_q || m_tready_i;
  assign out_load = advance && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q  <= hit;
      out_offset_q <= hit ? 32'(count_new - mbps_pkg::count_t'(match_cfg.len)) : 32'd0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_offset_q;
  assign m_tuser_o  = out_found_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MBPS_ASSERT_NOW(a_notfound_zero_offset, clk_i, rst_ni,
                   out_valid_q && !out_found_q, out_offset_q == 32'd0,
                   "not-found result carries a nonzero offset")

  `MBPS_ASSERT_NOW(a_load_only_when_free, clk_i, rst_ni,
                   out_load, out_free,
                   "result loaded while the pending result is stalled")

  `MBPS_ASSERT_NEXT(a_match_sets_flag, clk_i, rst_ni,
                    out_load && hit && !in_last_q, matched_q,
                    "match result without setting the match flag")

  `MBPS_ASSERT_NEXT(a_region_end_clears, clk_i, rst_ni,
                    advance && in_last_q, (count_q == '0) && !matched_q,
                    "region end did not clear the region state")

  `MBPS_ASSERT_NOW(a_stall_needs_pending, clk_i, rst_ni,
                   !s_tready_o, in_valid_q && produce && !out_free,
                   "input stalled without a blocked result")

endmodule
